### design/evad_pkg.sv
package evad_pkg;

    // Q15.8 saturation point (32768.0)
    localparam logic [23:0] Q8_SAT = 24'h800000;
    // Largest possible frame RMS
    localparam logic [15:0] RMS_MAX = 16'h8000;

    // Register reset values
    localparam logic [15:0] ABS_THR_RST     = 16'd500;
    localparam logic [11:0] NOISE_MULT_RST  = 12'd768;
    localparam logic [15:0] EMA_ALPHA_RST   = 16'd3277;
    localparam logic [7:0]  HANG_FRAMES_RST = 8'd15;
    // Noise floor after reset: absolute threshold reset value in Q15.8
    localparam logic [23:0] NF_RST          = 24'd128000;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_ABS_THR     = 2'd0;
    localparam logic [1:0] REG_NOISE_MULT  = 2'd1;
    localparam logic [1:0] REG_EMA_ALPHA   = 2'd2;
    localparam logic [1:0] REG_HANG_FRAMES = 2'd3;

    // Shared multiplier operand selection
    localparam logic [1:0] MUL_NF_GAIN   = 2'd0;
    localparam logic [1:0] MUL_NF_KEEP   = 2'd1;
    localparam logic [1:0] MUL_RMS_ALPHA = 2'd2;

    // Square root iterations (two radicand bits per step, 32-bit radicand)
    localparam int SQRT_STEPS = 16;

    // Result tdata width: 67 bits of fields rounded up to whole bytes
    localparam int OUT_W = 72;

    typedef struct packed {
        logic [15:0] abs_thr;
        logic [11:0] noise_mult;
        logic [15:0] ema_alpha;
        logic [7:0]  hang_frames;
    } evad_cfg_t;

    typedef struct packed {
        logic       acc;        // sample transfer
        logic       frame_end;  // transfer closes the frame, load divider
        logic       div_step;
        logic       sqrt_load;
        logic       sqrt_step;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       decide;     // update detector state and load result
    } evad_cmd_t;

    function automatic logic [23:0] sat_q8(input logic [40:0] v);
        logic [23:0] r;
        if (v > 41'(Q8_SAT)) begin
            r = Q8_SAT;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

### design/evad_cfg.sv
module evad_cfg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output evad_pkg::evad_cfg_t   cfg
);
    import evad_pkg::*;

    evad_cfg_t cfg_reg;
    logic      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Write registers on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.abs_thr     <= ABS_THR_RST;
            cfg_reg.noise_mult  <= NOISE_MULT_RST;
            cfg_reg.ema_alpha   <= EMA_ALPHA_RST;
            cfg_reg.hang_frames <= HANG_FRAMES_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_ABS_THR:     cfg_reg.abs_thr     <= pwdata[15:0];
                REG_NOISE_MULT:  cfg_reg.noise_mult  <= pwdata[11:0];
                REG_EMA_ALPHA:   cfg_reg.ema_alpha   <= pwdata[15:0];
                REG_HANG_FRAMES: cfg_reg.hang_frames <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (paddr[3:2])
            REG_ABS_THR:     prdata = {16'd0, cfg_reg.abs_thr};
            REG_NOISE_MULT:  prdata = {20'd0, cfg_reg.noise_mult};
            REG_EMA_ALPHA:   prdata = {16'd0, cfg_reg.ema_alpha};
            REG_HANG_FRAMES: prdata = {24'd0, cfg_reg.hang_frames};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

### design/evad_ctrl.sv
module evad_ctrl #(
    parameter int MAX_FRAME = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tlast,
    output logic                  s_axis_tready,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output evad_pkg::evad_cmd_t   cmd
);
    import evad_pkg::*;

    localparam int CNT_W  = $clog2(MAX_FRAME + 1);
    localparam int SUM_W  = 30 + CNT_W;
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [2:0] ST_ACC  = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SQL  = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_MUL0 = 3'd4;
    localparam logic [2:0] ST_MUL1 = 3'd5;
    localparam logic [2:0] ST_MUL2 = 3'd6;
    localparam logic [2:0] ST_DEC  = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              accept;
    logic              out_free;

    assign s_axis_tready = (state_reg == ST_ACC);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;

    // Sequence one frame close: divide, square root, three products, decide
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_ACC: begin
                cmd.acc       = accept;
                cmd.frame_end = accept && s_axis_tlast;
                if (accept && s_axis_tlast) begin
                    state_next = ST_DIV;
                    step_next  = '0;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    state_next = ST_SQL;
                end
            end
            ST_SQL: begin
                cmd.sqrt_load = 1'b1;
                step_next     = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    state_next = ST_MUL0;
                end
            end
            ST_MUL0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_NF_GAIN;
                state_next  = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_NF_KEEP;
                state_next  = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RMS_ALPHA;
                state_next  = ST_DEC;
            end
            ST_DEC: begin
                // Hold until the result register is free
                if (out_free) begin
                    cmd.decide = 1'b1;
                    state_next = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.decide) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACC;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### design/evad_datapath.sv
module evad_datapath #(
    parameter int MAX_FRAME = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  evad_pkg::evad_cmd_t        cmd,
    input  evad_pkg::evad_cfg_t        cfg,
    input  logic signed [15:0]         sample,
    output logic [evad_pkg::OUT_W-1:0] m_axis_tdata
);
    import evad_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int SUM_W = 30 + CNT_W;

    // Frame accumulator
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic signed [31:0] sq_s;
    logic [30:0]        sq_u;
    logic               add_ok;
    logic [SUM_W-1:0]   sum_inc;
    logic [CNT_W-1:0]   cnt_inc;

    // Divider
    logic [SUM_W-1:0]   quo_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   dvs_reg;
    logic [CNT_W:0]     drem_sh;
    logic [CNT_W:0]     drem_diff;
    logic               dge;

    // Square root
    logic [31:0]        rad_reg;
    logic [17:0]        srem_reg;
    logic [15:0]        root_reg;
    logic [19:0]        srem_sh;
    logic [19:0]        strial;
    logic [19:0]        sdiff;
    logic               sge;

    // Shared multiplier
    logic [23:0]        mul_a;
    logic [16:0]        mul_b;
    logic [40:0]        mul_p;
    logic [40:0]        gain_reg;
    logic [40:0]        keep_reg;
    logic [40:0]        rmsa_reg;

    // Detector state
    logic               speech_reg;
    logic [23:0]        nf_reg;
    logic [7:0]         hang_reg;

    // Decision terms
    logic [23:0]        q_rms;
    logic [23:0]        abs_q;
    logic [23:0]        mul_q;
    logic [23:0]        thr;
    logic [23:0]        ema_q;
    logic [40:0]        ema_sum;
    logic               loud;
    logic [7:0]         hang_dec;

    // Result payload
    logic               o_speech_reg;
    logic               o_started_reg;
    logic               o_ended_reg;
    logic [15:0]        o_rms_reg;
    logic [23:0]        o_nf_reg;
    logic [23:0]        o_thr_reg;

    // Accumulate squares, drop samples beyond the frame limit
    assign sq_s    = sample * sample;
    assign sq_u    = sq_s[30:0];
    assign add_ok  = cnt_reg < CNT_W'(MAX_FRAME);
    assign sum_inc = add_ok ? sum_reg + SUM_W'(sq_u) : sum_reg;
    assign cnt_inc = add_ok ? cnt_reg + CNT_W'(1) : cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.acc) begin
            if (cmd.frame_end) begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end else begin
                sum_reg <= sum_inc;
                cnt_reg <= cnt_inc;
            end
        end
    end

    // Restoring divide of sum by count, one quotient bit per cycle
    assign drem_sh   = {rem_reg, quo_reg[SUM_W-1]};
    assign drem_diff = drem_sh - {1'b0, dvs_reg};
    assign dge       = drem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (cmd.frame_end) begin
            quo_reg <= sum_inc;
            dvs_reg <= cnt_inc;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[SUM_W-2:0], dge};
            rem_reg <= dge ? drem_diff[CNT_W-1:0] : drem_sh[CNT_W-1:0];
        end
    end

    // Digit-by-digit square root, two radicand bits per cycle
    assign srem_sh = {srem_reg, rad_reg[31:30]};
    assign strial  = {2'b00, root_reg, 2'b01};
    assign sdiff   = srem_sh - strial;
    assign sge     = srem_sh >= strial;

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_load) begin
            // Zero count cannot close a frame; guard the mean anyway
            rad_reg  <= (dvs_reg == '0) ? 32'd0 : 32'(quo_reg);
            srem_reg <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg  <= {rad_reg[29:0], 2'b00};
            srem_reg <= sge ? sdiff[17:0] : srem_sh[17:0];
            root_reg <= {root_reg[14:0], sge};
        end
    end

    assign q_rms = {root_reg, 8'd0};

    // One multiplier, three products on successive cycles
    always_comb begin
        case (cmd.mul_sel)
            MUL_NF_GAIN: begin
                mul_a = nf_reg;
                mul_b = {5'd0, cfg.noise_mult};
            end
            MUL_NF_KEEP: begin
                mul_a = nf_reg;
                mul_b = 17'h10000 - {1'b0, cfg.ema_alpha};
            end
            MUL_RMS_ALPHA: begin
                mul_a = q_rms;
                mul_b = {1'b0, cfg.ema_alpha};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 41'(mul_a) * 41'(mul_b);

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            case (cmd.mul_sel)
                MUL_NF_GAIN:   gain_reg <= mul_p;
                MUL_NF_KEEP:   keep_reg <= mul_p;
                MUL_RMS_ALPHA: rmsa_reg <= mul_p;
                default: ;
            endcase
        end
    end

    // Threshold, loudness and smoothed floor
    assign abs_q    = sat_q8(41'({cfg.abs_thr, 8'd0}));
    assign mul_q    = sat_q8(gain_reg >> 8);
    assign thr      = (abs_q > mul_q) ? abs_q : mul_q;
    assign loud     = q_rms > thr;
    assign ema_sum  = keep_reg + rmsa_reg;
    assign ema_q    = sat_q8(ema_sum >> 16);
    assign hang_dec = (hang_reg == 8'd0) ? 8'd0 : hang_reg - 8'd1;

    // Silence/speech update and result load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speech_reg <= 1'b0;
            nf_reg     <= NF_RST;
            hang_reg   <= 8'd0;
        end else if (cmd.decide) begin
            if (!speech_reg) begin
                nf_reg <= ema_q;
                if (loud) begin
                    speech_reg <= 1'b1;
                    hang_reg   <= cfg.hang_frames;
                end
            end else if (loud) begin
                hang_reg <= cfg.hang_frames;
            end else begin
                hang_reg <= hang_dec;
                if (hang_dec == 8'd0) begin
                    speech_reg <= 1'b0;
                    nf_reg     <= q_rms;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            o_speech_reg  <= speech_reg ? !(!loud && hang_dec == 8'd0) : loud;
            o_started_reg <= !speech_reg && loud;
            o_ended_reg   <= speech_reg && !loud && hang_dec == 8'd0;
            o_rms_reg     <= root_reg;
            o_nf_reg      <= nf_reg;
            o_thr_reg     <= thr;
        end
    end

    assign m_axis_tdata = {5'd0, o_thr_reg, o_nf_reg, o_rms_reg,
                           o_ended_reg, o_started_reg, o_speech_reg};

endmodule

### design/energy_voice_activity_detector.sv
// Energy voice activity detector.
// Input stream: one signed 16-bit PCM sample per transfer on s_axis_tdata,
// s_axis_tlast marks the sample that closes a frame. Samples beyond
// MAX_FRAME in one frame are dropped, the closing mark still counts.
// Result stream: one transfer per closed frame on m_axis_tdata carrying the
// speech state, start/end events, frame RMS, noise floor and threshold.
// Configuration: APB registers at 0x0 absolute threshold, 0x4 noise
// multiplier (Q4.8), 0x8 EMA alpha (Q0.16), 0xC hang frames; write only
// while the block is idle.
// Sequencing: samples that do not close a frame are accepted back to back. A
// closing sample starts the frame-end sequence: the serial divider forms
// one quotient bit per step, a load step prepares the square root, which
// then forms one root bit per step, the shared multiplier forms three
// products, and a decision step loads the result once the result register
// is free. No sample is taken during that sequence.
// A result held by a stalled receiver does not block accumulation of the
// next frame; the next frame's decision waits until the result is taken.
// Reset (aresetn low, synchronous) restores register defaults, silence,
// a noise floor of 500.0 and empty accumulators, and drops a pending result.
module energy_voice_activity_detector #(
    parameter int MAX_FRAME = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // tdata: [15:0] sample
    input  logic [15:0]                s_axis_tdata,
    input  logic                       s_axis_tlast,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: [0] speech, [1] start_event, [2] end_event,
    //        [18:3] rms, [42:19] noise_floor_out, [66:43] threshold_out
    output logic [evad_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [3:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import evad_pkg::*;

    evad_cfg_t cfg;
    evad_cmd_t cmd;

    evad_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    evad_ctrl #(
        .MAX_FRAME (MAX_FRAME)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    evad_datapath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .cfg          (cfg),
        .sample       (s_axis_tdata),
        .m_axis_tdata (m_axis_tdata)
    );

endmodule

### design/evad_checker.sv
module evad_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic [evad_pkg::OUT_W-1:0] m_axis_tdata,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready
);
    import evad_pkg::*;

    // No result survives reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Events agree with the reported state
    a_event_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tdata[1] && !m_axis_tdata[0])
                          && !(m_axis_tdata[2] && m_axis_tdata[0]))
        else $error("event disagrees with speech state");

    // Threshold, noise floor and RMS stay within range
    a_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[66:43] <= Q8_SAT
                          && m_axis_tdata[42:19] <= Q8_SAT
                          && m_axis_tdata[18:3] <= RMS_MAX)
        else $error("result field out of range");

endmodule

bind energy_voice_activity_detector evad_checker u_evad_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
